[hdl/io_page_write_decoder_defines.svh]
// ---------------------------------------------------------------------------
// io page write decoder assertion macros
// shared concurrent assertion forms, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef IO_PAGE_WRITE_DECODER_DEFINES_SVH
`define IO_PAGE_WRITE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define IPWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IPWD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IPWD_ASSERT(label, clk, rst, prop, msg)
`define IPWD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/ipwd_pkg.sv]
// ---------------------------------------------------------------------------
// ipwd_pkg
// shared types and codes for the io page write decoder
// ---------------------------------------------------------------------------
`default_nettype none
package ipwd_pkg;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_SCREEN  = 3'd1,
      EV_CURSOR  = 3'd2,
      EV_COLOUR  = 3'd3,
      EV_PALETTE = 3'd4,
      EV_MODE    = 3'd5,
      EV_SOUND   = 3'd6,
      EV_LATCH   = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_MODE,
      ST_COLOUR,
      ST_SCAN,
      ST_SINGLE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       apply;      // commit request to state
      logic       load_ev;    // load output event register
      event_type  ev;
      logic       ev_flash;   // event payload from flash scan entry
      logic       scan_clr;   // reset scan counter
      logic       scan_inc;   // advance scan counter
      logic       set_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       mode_ev;    // control write changes teletext flag
      logic       colour_ev;  // control write changes chars per line
      logic       flash_go;   // flash scan needed
      logic       any_flash;  // at least one palette entry flashing
      event_type  first_code; // event of a non-control write
      logic       scan_hit;   // current scan entry flashing
      logic       scan_more;  // a flashing entry beyond the current one
      logic       is_ula;
   } status_type;

   localparam logic [15:0] TELETEXT_BASE = 16'h7400;
   localparam logic [15:0] TELETEXT_XOR  = 16'h2000;
   localparam logic [3:0]  CRTC_R1  = 4'd1;
   localparam logic [3:0]  CRTC_R12 = 4'd12;
   localparam logic [3:0]  CRTC_R13 = 4'd13;
   localparam logic [3:0]  CRTC_R14 = 4'd14;
   localparam logic [3:0]  CRTC_R15 = 4'd15;
   localparam logic [3:0]  VIA_ORB    = 4'd0;
   localparam logic [3:0]  VIA_ORA    = 4'd1;
   localparam logic [3:0]  VIA_DDRB   = 4'd2;
   localparam logic [3:0]  VIA_DDRA   = 4'd3;
   localparam logic [3:0]  VIA_IFR    = 4'd13;
   localparam logic [3:0]  VIA_IER    = 4'd14;
   localparam logic [3:0]  VIA_ORA_NH = 4'd15;
   localparam logic [7:0]  IER_SET  = 8'h80;
   localparam logic [2:0]  COL_MASK = 3'h7;

   function automatic logic [6:0] chars_of(input logic [1:0] sel);
      case (sel)
         2'd0:    chars_of = 7'd10;
         2'd1:    chars_of = 7'd20;
         2'd2:    chars_of = 7'd40;
         default: chars_of = 7'd80;
      endcase
   endfunction

endpackage
`default_nettype wire

[hdl/ipwd_datapath.sv]
// ---------------------------------------------------------------------------
// ipwd_datapath
// register files, decode of one write and the result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "io_page_write_decoder_defines.svh"
module ipwd_datapath
   import ipwd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_offset,
   input  wire logic [7:0]  req_data,
   input  wire logic [7:0]  req_key_code,
   input  wire logic        capture,
   input  wire cmd_type     cmd,
   output status_type       sts,
   output logic [2:0]       rsp_event_res,
   output logic [15:0]      rsp_value,
   output logic [3:0]       rsp_pal_index,
   output logic             rsp_teletext_mode,
   output logic [6:0]       rsp_chars_per_line,
   output logic [7:0]       rsp_irq_flags,
   output logic [7:0]       rsp_irq_enable,
   output logic [7:0]       rsp_port_a_value,
   output logic [7:0]       rsp_port_b_value,
   output logic [7:0]       rsp_rom_bank,
   output logic             rsp_last
);

   // captured request
   logic [7:0] off_ff, dat_ff, key_ff;
   // state
   logic [7:0] crtc_index_ff;
   logic [7:0] crtc_file_ff [16];
   logic [7:0] ula_ff;
   logic       tt_ff;
   logic [6:0] chars_ff;
   logic [3:0] pal_ff [16];
   logic [7:0] rom_ff;
   logic [7:0] via_ff [16];
   logic [7:0] pa_ff, pb_ff;
   logic [7:0] latch_ff;
   logic [3:0] scan_ff;
   // output register
   logic [2:0]  ev_ff;
   logic [15:0] val_ff;
   logic [3:0]  idx_ff;
   logic        last_ff;
   logic        out_tt_ff;
   logic [6:0]  out_chars_ff;
   logic [7:0]  out_ifr_ff, out_ier_ff, out_pa_ff, out_pb_ff, out_rom_ff;

   // decode
   logic is_crtc, is_ula, is_pal, is_rom, is_via;
   logic [3:0] reg_sel, crtc_sel;
   logic       crtc_ok;
   logic [6:0] new_chars;
   logic       new_tt;
   logic [7:0] new_pa, new_pb;
   logic       key_hit;
   logic [15:0] base_w, scr_w;
   logic       chars_ok;

   always_comb begin
      is_crtc = (off_ff[7:3] == 5'd0);
      is_ula  = (off_ff[7:4] == 4'h2) && !off_ff[0];
      is_pal  = (off_ff[7:4] == 4'h2) && off_ff[0];
      is_rom  = (off_ff[7:4] == 4'h3);
      is_via  = (off_ff[7:5] == 3'b010);
      reg_sel = off_ff[3:0];
      crtc_sel = crtc_index_ff[3:0];
      crtc_ok = (crtc_index_ff[7:4] == 4'd0);
      new_tt = dat_ff[1];
      new_chars = chars_of(dat_ff[3:2]);
      new_pa = dat_ff & via_ff[VIA_DDRA];
      new_pb = dat_ff & via_ff[VIA_DDRB];
      key_hit = !latch_ff[3] && key_ff != 8'd0 && key_ff[3:0] == new_pa[3:0];
   end

   // status to the controller
   always_comb begin
      sts = '0;
      sts.is_ula    = is_ula;
      sts.mode_ev   = is_ula && (new_tt != tt_ff);
      sts.colour_ev = is_ula && (new_chars != chars_ff);
      sts.flash_go  = is_ula && (dat_ff[0] != ula_ff[0]) && !new_tt;
      sts.first_code = EV_NONE;
      if (is_crtc && off_ff[0] && crtc_ok) begin
         if (crtc_sel == CRTC_R1) begin
            sts.first_code = EV_COLOUR;
         end else if (crtc_sel == CRTC_R13) begin
            sts.first_code = EV_SCREEN;
         end else if (crtc_sel == CRTC_R15) begin
            sts.first_code = EV_CURSOR;
         end
      end else if (is_pal) begin
         sts.first_code = EV_PALETTE;
      end else if (is_via && reg_sel == VIA_ORB) begin
         if (dat_ff[2:0] == 3'd0) begin
            sts.first_code = EV_SOUND;
         end else if ((dat_ff[2:0] inside {3'd4, 3'd5}) && !tt_ff) begin
            sts.first_code = EV_LATCH;
         end
      end
      sts.any_flash = 1'b0;
      sts.scan_more = 1'b0;
      for (int j = 0; j < 16; j++) begin
         if (pal_ff[j][3]) begin
            sts.any_flash = 1'b1;
            if (4'(j) > scan_ff) sts.scan_more = 1'b1;
         end
      end
      sts.scan_hit = pal_ff[scan_ff][3];
   end

   // screen address from registers 12/13 (read after the apply cycle)
   always_comb begin
      base_w = {crtc_file_ff[CRTC_R12], crtc_file_ff[CRTC_R13]};
      scr_w = tt_ff ? (TELETEXT_BASE + (base_w ^ TELETEXT_XOR))
                    : {base_w[12:0], 3'b000};
   end

   // request capture and state update
   always_ff @(posedge clock) begin
      if (capture) begin
         off_ff <= req_offset;
         dat_ff <= req_data;
         key_ff <= req_key_code;
      end
      if (reset) begin
         crtc_index_ff <= '0;
         ula_ff <= '0;
         tt_ff <= 1'b0;
         chars_ff <= '0;
         rom_ff <= '0;
         pa_ff <= '0;
         pb_ff <= '0;
         latch_ff <= '0;
         for (int i = 0; i < 16; i++) begin
            crtc_file_ff[i] <= '0;
            pal_ff[i] <= '0;
            via_ff[i] <= '0;
         end
      end else if (cmd.apply) begin
         if (is_crtc) begin
            if (!off_ff[0]) crtc_index_ff <= dat_ff;
            else if (crtc_ok) crtc_file_ff[crtc_sel] <= dat_ff;
         end
         if (is_ula) begin
            ula_ff <= dat_ff;
            tt_ff <= new_tt;
            chars_ff <= new_chars;
         end
         if (is_pal) pal_ff[dat_ff[7:4]] <= dat_ff[3:0];
         if (is_rom) rom_ff <= dat_ff;
         if (is_via) begin
            case (reg_sel)
               VIA_ORB: begin
                  via_ff[VIA_ORB] <= dat_ff;
                  pb_ff <= new_pb;
                  latch_ff[new_pb[2:0]] <= new_pb[3];
               end
               VIA_ORA, VIA_ORA_NH: begin
                  via_ff[VIA_ORA] <= dat_ff;
                  pa_ff <= new_pa;
                  if (key_hit) via_ff[VIA_IFR] <= via_ff[VIA_IFR] | 8'h01;
               end
               VIA_DDRB: begin
                  via_ff[VIA_DDRB] <= dat_ff;
                  pb_ff <= dat_ff & via_ff[VIA_ORB];
               end
               VIA_DDRA: begin
                  via_ff[VIA_DDRA] <= dat_ff;
                  pa_ff <= dat_ff & via_ff[VIA_ORA];
               end
               VIA_IFR: via_ff[VIA_IFR] <= via_ff[VIA_IFR] & ~dat_ff;
               VIA_IER: via_ff[VIA_IER] <= (dat_ff[7] ? (via_ff[VIA_IER] | dat_ff)
                                                      : (via_ff[VIA_IER] & ~dat_ff))
                                           | IER_SET;
               default: via_ff[reg_sel] <= dat_ff;
            endcase
         end
      end
   end

   // flash scan counter
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clr) scan_ff <= '0;
      else if (cmd.scan_inc) scan_ff <= scan_ff + 4'd1;
   end

   // result register, filled after state is committed
   always_ff @(posedge clock) begin
      if (cmd.load_ev) begin
         ev_ff <= cmd.ev;
         last_ff <= cmd.set_last;
         out_tt_ff <= tt_ff;
         out_chars_ff <= chars_ff;
         out_ifr_ff <= via_ff[VIA_IFR];
         out_ier_ff <= via_ff[VIA_IER];
         out_pa_ff <= pa_ff;
         out_pb_ff <= pb_ff;
         out_rom_ff <= rom_ff;
         val_ff <= '0;
         idx_ff <= '0;
         if (cmd.ev_flash) begin
            val_ff <= {13'd0, ula_ff[0] ? pal_ff[scan_ff][2:0]
                                        : (pal_ff[scan_ff][2:0] ^ COL_MASK)};
            idx_ff <= scan_ff;
         end else begin
            case (cmd.ev)
               EV_SCREEN:  val_ff <= scr_w;
               EV_CURSOR:  val_ff <= {crtc_file_ff[CRTC_R14], crtc_file_ff[CRTC_R15]};
               EV_PALETTE: begin
                  val_ff <= {13'd0, dat_ff[2:0] ^ COL_MASK};
                  idx_ff <= dat_ff[7:4];
               end
               EV_MODE:    val_ff <= {15'd0, tt_ff};
               EV_SOUND:   val_ff <= {8'd0, pa_ff};
               default:    val_ff <= '0;
            endcase
         end
      end
   end

   assign rsp_event_res      = ev_ff;
   assign rsp_value          = val_ff;
   assign rsp_pal_index      = idx_ff;
   assign rsp_teletext_mode  = out_tt_ff;
   assign rsp_chars_per_line = out_chars_ff;
   assign rsp_irq_flags      = out_ifr_ff;
   assign rsp_irq_enable     = out_ier_ff;
   assign rsp_port_a_value   = out_pa_ff;
   assign rsp_port_b_value   = out_pb_ff;
   assign rsp_rom_bank       = out_rom_ff;
   assign rsp_last           = last_ff;

   assign chars_ok = (chars_ff == 7'd0) || (chars_ff == 7'd10) || (chars_ff == 7'd20) ||
                     (chars_ff == 7'd40) || (chars_ff == 7'd80);

   // checks
   `IPWD_ASSERT(a_ier_top, clock, reset, (via_ff[VIA_IER] != 8'd0) |-> via_ff[VIA_IER][7], "ier bit 7 not set")
   `IPWD_ASSERT(a_chars, clock, reset, chars_ok, "bad chars per line")
   `IPWD_ASSERT(a_scan_clr, clock, reset, cmd.scan_clr |=> (scan_ff == 4'd0), "scan not cleared")

endmodule
`default_nettype wire

[hdl/ipwd_control.sv]
// ---------------------------------------------------------------------------
// ipwd_control
// sequencer: capture, commit, then emit each event of one request
// ---------------------------------------------------------------------------
`default_nettype none
`include "io_page_write_decoder_defines.svh"
module ipwd_control
   import ipwd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             capture,
   output cmd_type          cmd,
   input  wire status_type  sts
);

   // ST_APPLY commits; ST_MODE/COLOUR/SCAN emit control write events
   state_type state_ff, state_in;
   logic      mode_p_ff, mode_p_in;
   logic      colour_p_ff, colour_p_in;
   logic      scan_p_ff, scan_p_in;
   event_type first_ff, first_in;
   logic      rv_ff, rv_in;
   logic      out_free;
   logic      more_ctl;

   assign out_free  = !rv_ff || rsp_ready;
   assign rsp_valid = rv_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign capture   = req_valid && req_ready;
   assign more_ctl  = colour_p_ff || scan_p_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      mode_p_in = mode_p_ff;
      colour_p_in = colour_p_ff;
      scan_p_in = scan_p_ff;
      first_in = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (capture) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // decide the event list from the state before commit
            mode_p_in = sts.mode_ev;
            colour_p_in = sts.colour_ev;
            scan_p_in = sts.flash_go && sts.any_flash;
            first_in = sts.first_code;
            state_in = sts.is_ula ? ST_MODE : ST_SINGLE;
         end
         ST_MODE: begin
            if (!mode_p_ff && more_ctl) state_in = ST_COLOUR;
            else if (out_free) state_in = more_ctl ? ST_COLOUR : ST_IDLE;
         end
         ST_COLOUR: begin
            if (!colour_p_ff) state_in = ST_SCAN;
            else if (out_free) state_in = scan_p_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (!sts.scan_more && (!sts.scan_hit || out_free)) state_in = ST_IDLE;
         end
         ST_SINGLE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_APPLY: begin
            cmd.apply = 1'b1;
            cmd.scan_clr = 1'b1;
         end
         ST_MODE: begin
            if ((mode_p_ff || !more_ctl) && out_free) begin
               cmd.load_ev = 1'b1;
               cmd.ev = mode_p_ff ? EV_MODE : EV_NONE;
               cmd.set_last = !more_ctl;
            end
         end
         ST_COLOUR: begin
            if (colour_p_ff && out_free) begin
               cmd.load_ev = 1'b1;
               cmd.ev = EV_COLOUR;
               cmd.set_last = !scan_p_ff;
            end
         end
         ST_SCAN: begin
            // one palette entry per cycle while the output is free, last on the final flashing entry
            if (sts.scan_hit) begin
               if (out_free) begin
                  cmd.load_ev = 1'b1;
                  cmd.ev = EV_PALETTE;
                  cmd.ev_flash = 1'b1;
                  cmd.set_last = !sts.scan_more;
                  cmd.scan_inc = sts.scan_more;
               end
            end else begin
               cmd.scan_inc = sts.scan_more;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               cmd.load_ev = 1'b1;
               cmd.ev = first_ff;
               cmd.set_last = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
      rv_in = (rv_ff && !rsp_ready) || cmd.load_ev;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_p_ff <= 1'b0;
         colour_p_ff <= 1'b0;
         scan_p_ff <= 1'b0;
         first_ff <= EV_NONE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_p_ff <= mode_p_in;
         colour_p_ff <= colour_p_in;
         scan_p_ff <= scan_p_in;
         first_ff <= first_in;
         rv_ff <= rv_in;
      end
   end

   `IPWD_ASSERT(a_no_overrun, clock, reset, (rv_ff && !rsp_ready) |-> !cmd.load_ev, "result overwritten")
   `IPWD_ASSERT(a_one_req, clock, reset, capture |=> !req_ready, "second request while busy")
   `IPWD_ASSERT(a_apply_once, clock, reset, cmd.apply |=> !cmd.apply, "double commit")

endmodule
`default_nettype wire

[hdl/io_page_write_decoder.sv]
// ---------------------------------------------------------------------------
// io_page_write_decoder
// decodes processor writes into the io page and reports resulting events
// ---------------------------------------------------------------------------
// first result: request captured, committed, then loaded into the result
//   register; a flash toggle in graphics mode scans palette entries up to the
//   last flashing one (one entry per cycle while the output is free)
// output stalls hold the sequencer; next request once the last result loads
// reset: synchronous, active high, clears all register files and state
`default_nettype none
module io_page_write_decoder
   import ipwd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_offset,
   input  wire logic [7:0]  req_data,
   input  wire logic [7:0]  req_key_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [15:0]      rsp_value,
   output logic [3:0]       rsp_pal_index,
   output logic             rsp_teletext_mode,
   output logic [6:0]       rsp_chars_per_line,
   output logic [7:0]       rsp_irq_flags,
   output logic [7:0]       rsp_irq_enable,
   output logic [7:0]       rsp_port_a_value,
   output logic [7:0]       rsp_port_b_value,
   output logic [7:0]       rsp_rom_bank,
   output logic             rsp_last
);

   cmd_type    cmd;
   status_type sts;
   logic       capture;

   // sequencer
   ipwd_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .capture, .cmd, .sts
   );

   // state and result path
   ipwd_datapath u_datapath (
      .clock, .reset, .req_offset, .req_data, .req_key_code, .capture, .cmd, .sts,
      .rsp_event_res, .rsp_value, .rsp_pal_index, .rsp_teletext_mode,
      .rsp_chars_per_line, .rsp_irq_flags, .rsp_irq_enable, .rsp_port_a_value,
      .rsp_port_b_value, .rsp_rom_bank, .rsp_last
   );

endmodule
`default_nettype wire

[dv/io_page_write_checker.sv]
// ---------------------------------------------------------------------------
// io page write checker
// watches both channels, predicts the events of each accepted request and
// compares every result field by field against the oldest prediction
// ---------------------------------------------------------------------------
`default_nettype none
module io_page_write_checker
   import ipwd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_offset,
   input  wire logic [7:0]  req_data,
   input  wire logic [7:0]  req_key_code,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_event_res,
   input  wire logic [15:0] rsp_value,
   input  wire logic [3:0]  rsp_pal_index,
   input  wire logic        rsp_teletext_mode,
   input  wire logic [6:0]  rsp_chars_per_line,
   input  wire logic [7:0]  rsp_irq_flags,
   input  wire logic [7:0]  rsp_irq_enable,
   input  wire logic [7:0]  rsp_port_a_value,
   input  wire logic [7:0]  rsp_port_b_value,
   input  wire logic [7:0]  rsp_rom_bank,
   input  wire logic        rsp_last,
   output int               error_count,
   output int               pending_count,
   output int               event_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      event_type   ev;
      logic [15:0] value;
      logic [3:0]  pal;
      logic        ttx;
      logic [6:0]  chars;
      logic [7:0]  ifr;
      logic [7:0]  ier;
      logic [7:0]  pa;
      logic [7:0]  pb;
      logic [7:0]  rom;
      logic        last;
   } io_event_type;

   io_event_type expected_events[$];
   io_event_type burst[$];

   // model state
   logic [7:0]  m_crtc_sel;
   logic [7:0]  m_crtc[16];
   logic [7:0]  m_ctrl;
   logic        m_ttx;
   logic [6:0]  m_chars;
   logic [3:0]  m_pal[16];
   logic [7:0]  m_rom;
   logic [7:0]  m_via[16];
   logic [7:0]  m_pa;
   logic [7:0]  m_pb;
   logic        m_latch[8];

   task automatic push_event(input event_type ev, input logic [15:0] v,
                             input logic [3:0] idx);
      io_event_type e;
      e = '0;
      e.ev = ev;
      e.value = v;
      e.pal = idx;
      burst.push_back(e);
   endtask

   task automatic decode_write(input logic [7:0] off, input logic [7:0] d,
                               input logic [7:0] key);
      logic [15:0] start;
      logic        old_flash;
      logic [6:0]  old_chars;
      logic [3:0]  reg_sel;
      burst.delete();
      if (off <= 8'h07) begin
         if (off[0]) begin
            if (m_crtc_sel <= 8'd15) begin
               m_crtc[m_crtc_sel[3:0]] = d;
               start = {m_crtc[CRTC_R12], m_crtc[CRTC_R13]};
               if (m_crtc_sel[3:0] == CRTC_R1)
                  push_event(EV_COLOUR, 16'd0, 4'd0);
               else if (m_crtc_sel[3:0] == CRTC_R13) begin
                  if (m_ttx)
                     push_event(EV_SCREEN, TELETEXT_BASE + (start ^ TELETEXT_XOR), 4'd0);
                  else
                     push_event(EV_SCREEN, start << 3, 4'd0);
               end else if (m_crtc_sel[3:0] == CRTC_R15)
                  push_event(EV_CURSOR, {m_crtc[CRTC_R14], m_crtc[CRTC_R15]}, 4'd0);
            end
         end else
            m_crtc_sel = d;
      end else if (off >= 8'h20 && off <= 8'h2F) begin
         if (off[0]) begin
            m_pal[d[7:4]] = d[3:0];
            push_event(EV_PALETTE, {13'd0, d[2:0] ^ COL_MASK}, d[7:4]);
         end else begin
            old_flash = m_ctrl[0];
            old_chars = m_chars;
            m_ctrl = d;
            if (!d[1] && m_ttx) begin
               m_ttx = 1'b0;
               push_event(EV_MODE, 16'd0, 4'd0);
            end
            if (d[1] && !m_ttx) begin
               m_ttx = 1'b1;
               push_event(EV_MODE, 16'd1, 4'd0);
            end
            case (d[3:2])
               2'd0: m_chars = 7'd10;
               2'd1: m_chars = 7'd20;
               2'd2: m_chars = 7'd40;
               default: m_chars = 7'd80;
            endcase
            if (old_chars != m_chars)
               push_event(EV_COLOUR, 16'd0, 4'd0);
            // flash toggle re-emits flashing entries in graphics mode
            if (old_flash != d[0] && !m_ttx)
               for (int c = 0; c < 16; c++)
                  if (m_pal[c][3])
                     push_event(EV_PALETTE,
                        {13'd0, d[0] ? m_pal[c][2:0] : m_pal[c][2:0] ^ COL_MASK},
                        c[3:0]);
         end
      end else if (off >= 8'h30 && off <= 8'h3F)
         m_rom = d;
      else if (off >= 8'h40 && off <= 8'h5F) begin
         reg_sel = off[3:0];
         case (reg_sel)
            VIA_ORB: begin
               m_via[VIA_ORB] = d;
               m_pb = d & m_via[VIA_DDRB];
               m_latch[m_pb[2:0]] = m_pb[3];
               if ((d[2:0] inside {3'd4, 3'd5}) && !m_ttx)
                  push_event(EV_LATCH, 16'd0, 4'd0);
               if (d[2:0] == 3'd0)
                  push_event(EV_SOUND, {8'd0, m_pa}, 4'd0);
            end
            VIA_ORA, VIA_ORA_NH: begin
               m_via[VIA_ORA] = d;
               m_pa = d & m_via[VIA_DDRA];
               if (!m_latch[3] && key != 8'd0 && key[3:0] == m_pa[3:0])
                  m_via[VIA_IFR][0] = 1'b1;
            end
            VIA_DDRB: begin
               m_via[VIA_DDRB] = d;
               m_pb = d & m_via[VIA_ORB];
            end
            VIA_DDRA: begin
               m_via[VIA_DDRA] = d;
               m_pa = d & m_via[VIA_ORA];
            end
            VIA_IFR: m_via[VIA_IFR] = m_via[VIA_IFR] & ~d;
            VIA_IER: begin
               if (d[7]) m_via[VIA_IER] = m_via[VIA_IER] | d;
               else m_via[VIA_IER] = m_via[VIA_IER] & ~d;
               m_via[VIA_IER] = m_via[VIA_IER] | IER_SET;
            end
            default: m_via[reg_sel] = d;
         endcase
      end
      if (burst.size() == 0)
         push_event(EV_NONE, 16'd0, 4'd0);
      // state fields reflect the state after the write
      foreach (burst[k]) begin
         burst[k].ttx = m_ttx;
         burst[k].chars = m_chars;
         burst[k].ifr = m_via[VIA_IFR];
         burst[k].ier = m_via[VIA_IER];
         burst[k].pa = m_pa;
         burst[k].pb = m_pb;
         burst[k].rom = m_rom;
         burst[k].last = (k == burst.size() - 1);
         expected_events.push_back(burst[k]);
      end
   endtask

   task automatic compare(input string name, input logic [15:0] exp_v,
                          input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   assign pending_count = expected_events.size();

   always @(posedge clock) begin
      io_event_type e;
      if (reset) begin
         m_crtc_sel = '0;
         m_ctrl = '0;
         m_ttx = 1'b0;
         m_chars = '0;
         m_rom = '0;
         m_pa = '0;
         m_pb = '0;
         for (int i = 0; i < 16; i++) begin
            m_crtc[i] = '0;
            m_pal[i] = '0;
            m_via[i] = '0;
         end
         for (int i = 0; i < 8; i++) m_latch[i] = 1'b0;
         expected_events.delete();
      end else begin
         // compare result before predicting, the request cannot overtake
         if (rsp_valid && rsp_ready) begin
            event_seen++;
            if (expected_events.size() == 0) begin
               $error("result with no request pending");
               error_count++;
            end else begin
               e = expected_events.pop_front();
               compare("event_res", e.ev, rsp_event_res);
               compare("value", e.value, rsp_value);
               compare("pal_index", e.pal, rsp_pal_index);
               compare("teletext_mode", e.ttx, rsp_teletext_mode);
               compare("chars_per_line", e.chars, rsp_chars_per_line);
               compare("irq_flags", e.ifr, rsp_irq_flags);
               compare("irq_enable", e.ier, rsp_irq_enable);
               compare("port_a_value", e.pa, rsp_port_a_value);
               compare("port_b_value", e.pb, rsp_port_b_value);
               compare("rom_bank", e.rom, rsp_rom_bank);
               compare("last", e.last, rsp_last);
            end
         end
         if (req_valid && req_ready)
            decode_write(req_offset, req_data, req_key_code);
      end
   end

   initial begin
      error_count = 0;
      event_seen = 0;
   end
endmodule
`default_nettype wire

[dv/tb_io_page_write_decoder.sv]
// ---------------------------------------------------------------------------
// tb_io_page_write_decoder
// directed and random io page writes with random idling on both sides
// ---------------------------------------------------------------------------
`default_nettype none
module tb_io_page_write_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_offset = '0;
   logic [7:0]  req_data = '0;
   logic [7:0]  req_key_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_value;
   logic [3:0]  rsp_pal_index;
   logic        rsp_teletext_mode;
   logic [6:0]  rsp_chars_per_line;
   logic [7:0]  rsp_irq_flags;
   logic [7:0]  rsp_irq_enable;
   logic [7:0]  rsp_port_a_value;
   logic [7:0]  rsp_port_b_value;
   logic [7:0]  rsp_rom_bank;
   logic        rsp_last;

   int          error_count;
   int          pending_count;
   int          event_seen;
   int          sent_count = 0;
   int          rsp_idle = 0;     // remaining receiver idle cycles
   bit          calm = 1'b0;      // no idling in the final part
   bit          hold_rsp = 1'b0;  // long receiver hold-off

   always #6 clock = ~clock;

   io_page_write_decoder dut (.*);

   io_page_write_checker checker_i (.*);

   // offer one request and wait for its acceptance
   task automatic send_write(input logic [7:0] off, input logic [7:0] d,
                             input logic [7:0] key);
      req_offset <= off;
      req_data <= d;
      req_key_code <= key;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // random write biased toward decoded regions
   task automatic random_write();
      logic [7:0] off;
      logic [7:0] d;
      logic [7:0] key;
      d = 8'($urandom);
      key = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1: off = 8'($urandom_range(0, 7));
         2:    off = 8'($urandom_range(0, 7)) & 8'hFE;
         3, 4: off = 8'($urandom_range(8'h20, 8'h2F));
         5:    off = 8'($urandom_range(8'h30, 8'h3F));
         6, 7, 8: off = 8'($urandom_range(8'h40, 8'h5F));
         default: off = 8'($urandom);
      endcase
      // keep crt select mostly inside the file so data writes reach it
      if (off <= 8'h07 && !off[0] && $urandom_range(0, 4) != 0)
         d = 8'($urandom_range(0, 15));
      if (off[7:4] == 4'h4 && key != 0 && $urandom_range(0, 1) == 0)
         key[3:0] = d[3:0];
      send_write(off, d, key);
   endtask

   // receiver side, random idle bursts
   always @(posedge clock) begin
      if (hold_rsp)
         rsp_ready <= 1'b0;
      else if (rsp_idle != 0)
         rsp_idle <= rsp_idle - 1;
      else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_idle <= $urandom_range(0, 6);
      end else
         rsp_ready <= 1'b1;
   end

   // receiver hold-off process
   initial begin
      wait (sent_count == 40);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: crt select, screen/cursor/colour, out-of-range select
      send_write(8'h00, 8'd12, 8'd0);
      send_write(8'h01, 8'hFF, 8'd0);
      send_write(8'h00, 8'd13, 8'd0);
      send_write(8'h01, 8'hFF, 8'd0);
      send_write(8'h06, 8'd14, 8'd0);
      send_write(8'h07, 8'hAB, 8'd0);
      send_write(8'h00, 8'd15, 8'd0);
      send_write(8'h03, 8'hCD, 8'd0);
      send_write(8'h00, 8'd1, 8'd0);
      send_write(8'h05, 8'd40, 8'd0);
      send_write(8'h00, 8'hFF, 8'd0);
      send_write(8'h01, 8'h55, 8'd0);
      // palette with flashing entries, flash toggle, teletext and back
      send_write(8'h21, 8'hF8, 8'd0);
      send_write(8'h2F, 8'h0F, 8'd0);
      send_write(8'h20, 8'h0D, 8'd0);
      send_write(8'h20, 8'h0E, 8'd0);
      send_write(8'h00, 8'd13, 8'd0);
      send_write(8'h01, 8'h00, 8'd0);
      send_write(8'h20, 8'h01, 8'd0);
      // via: directions, ports, key match, flags, enable, rom, ignored
      send_write(8'h43, 8'hFF, 8'd0);
      send_write(8'h42, 8'hFF, 8'd0);
      send_write(8'h41, 8'h37, 8'h87);
      send_write(8'h4E, 8'h7F, 8'd0);
      send_write(8'h5D, 8'hFF, 8'd0);
      send_write(8'h3A, 8'hFF, 8'hFF);
      send_write(8'hFF, 8'hFF, 8'hFF);
      // random phase
      for (int i = 0; i < 120; i++)
         random_write();
      // sender pause until drained
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
      for (int i = 0; i < 80; i++)
         random_write();
      calm = 1'b1;
      for (int i = 0; i < 40; i++)
         random_write();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (30) @(posedge clock);
      $display("covered %0d writes producing %0d events across crt, video, palette,",
               sent_count, event_seen);
      $display("rom latch and via registers with random stalls on both channels");
      if (error_count == 0)
         $display("tb_io_page_write_decoder: done, clean");
      else
         $display("tb_io_page_write_decoder: done, errors");
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_io_page_write_decoder: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/ipwd_pkg.sv
hdl/ipwd_datapath.sv
hdl/ipwd_control.sv
hdl/io_page_write_decoder.sv
dv/io_page_write_checker.sv
dv/tb_io_page_write_decoder.sv
